// File: src/ilsd_pkg.sv
// ----------------------------------------------------------------------------
// ilsd_pkg: shared types and constants for the indexed list
// Sizes of the list, operation and status codes, the command word that the
// controller broadcasts to every storage cell, and width helpers.
// ----------------------------------------------------------------------------
package ilsd_pkg;

    // Sizes of the list.
    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Operation codes carried by a request.
    localparam logic [2:0] OP_GET       = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_PUSH      = 3'd2;
    localparam logic [2:0] OP_POP       = 3'd3;
    localparam logic [2:0] OP_REMOVE_AT = 3'd4;
    localparam logic [2:0] OP_REMOVE_EQ = 3'd5;

    // Status codes returned with each result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Commands that every cell decodes in the same cycle.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_MARK_AT,
        CMD_MARK_EQ,
        CMD_SHIFT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t              cmd;
        logic [IDX_W-1:0]       sel;
        logic [CNT_W-1:0]       count;
        logic [WORD_WIDTH-1:0]  word;
    } cell_ctrl_t;

    // What a cell reports back to the controller and to its neighbors.
    typedef struct packed {
        logic drop;
        logic hole;
    } cell_stat_t;

    // Keep the low bits of a 32-bit request word that fit a list entry.
    function automatic logic [WORD_WIDTH-1:0] to_entry(input logic [31:0] w);
        logic [WORD_WIDTH+31:0] ext;
        ext = {{WORD_WIDTH{1'b0}}, w};
        return ext[WORD_WIDTH-1:0];
    endfunction

    // Fit a list entry into the 32-bit result field.
    function automatic logic [31:0] to_out_word(input logic [WORD_WIDTH-1:0] w);
        logic [WORD_WIDTH+31:0] ext;
        ext = {32'b0, w};
        return ext[31:0];
    endfunction

    // Fit a count into the 5-bit result fields.
    function automatic logic [4:0] to_out_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] ext;
        ext = {5'b0, c};
        return ext[4:0];
    endfunction

endpackage

// File: src/ilsd_cell.sv
// ----------------------------------------------------------------------------
// ilsd_cell: one storage cell of the list
// Holds one entry and a drop mark. On a shift command every cell at or above
// the lowest marked cell takes the entry and mark of its upper neighbor.
// ----------------------------------------------------------------------------
module ilsd_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ilsd_pkg::IDX_W-1:0]         cell_idx,
    input  ilsd_pkg::cell_ctrl_t               ctrl,
    input  logic [ilsd_pkg::WORD_WIDTH-1:0]    up_word,
    input  logic                               up_drop,
    input  logic                               hole_in,
    output logic [ilsd_pkg::WORD_WIDTH-1:0]    word,
    output ilsd_pkg::cell_stat_t               stat
);

    logic [ilsd_pkg::WORD_WIDTH-1:0] word_reg;
    logic [ilsd_pkg::WORD_WIDTH-1:0] word_next;
    logic                            drop_reg;
    logic                            drop_next;
    logic                            hit;
    logic                            live;
    logic                            hole_here;

    // Decode of the broadcast command for this cell.
    assign hit       = (cell_idx == ctrl.sel);
    assign live      = (ilsd_pkg::CNT_W'(cell_idx) < ctrl.count);
    assign hole_here = hole_in | drop_reg;

    always_comb
    begin
        word_next = word_reg;
        drop_next = drop_reg;
        case (ctrl.cmd)
            ilsd_pkg::CMD_LOAD:
            begin
                if (hit)
                begin
                    word_next = ctrl.word;
                end
            end
            ilsd_pkg::CMD_MARK_AT:
            begin
                drop_next = hit;
            end
            ilsd_pkg::CMD_MARK_EQ:
            begin
                drop_next = live && (word_reg == ctrl.word);
            end
            ilsd_pkg::CMD_SHIFT:
            begin
                if (hole_here)
                begin
                    word_next = up_word;
                    drop_next = up_drop;
                end
            end
            default:
            begin
                word_next = word_reg;
                drop_next = drop_reg;
            end
        endcase
    end

    // The entry itself needs no reset; the drop mark does.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else
        begin
            drop_reg <= drop_next;
        end
    end

    assign word      = word_reg;
    assign stat.drop = drop_reg;
    assign stat.hole = hole_here;

endmodule

// File: src/indexed_list_with_shift_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_with_shift_delete: bounded ordered list with compacting delete
// A row of storage cells driven by one controller. Get, set, push and pop
// act in one step; removals mark cells and then close the gaps by shifting.
//
//   Channel   Signals                                                        Dir
//   request   in_valid, in_ready, opcode, position, operand_word             in
//   result    out_valid, out_ready, read_word, status, entry_count,          out
//             removed_count
//
// Get, set, push, pop, the unused opcodes and a remove at an index past the
// end are captured in S_IDLE; in S_EXEC the cells act and the result
// register is loaded. A valid remove at index or a remove by value marks
// cells in S_EXEC and then compacts in S_COMPACT: the cell row closes one
// gap per cycle, the lowest one first, and the last gap waits while the
// result register is still full.
// Reset clears the count and the drop marks; entries hold no reset value.
// A new request is taken while an earlier result waits; the final step of a
// request stalls while the result register is still full.
// ----------------------------------------------------------------------------
module indexed_list_with_shift_delete (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  position,
    input  logic [31:0] operand_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_word,
    output logic [1:0]  status,
    output logic [4:0]  entry_count,
    output logic [4:0]  removed_count
);

    localparam int CAP = ilsd_pkg::CAPACITY;
    localparam int WW  = ilsd_pkg::WORD_WIDTH;
    localparam int IW  = ilsd_pkg::IDX_W;
    localparam int CW  = ilsd_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [2:0]             op_reg;
    logic [2:0]             op_next;
    logic [3:0]             pos_reg;
    logic [3:0]             pos_next;
    logic [WW-1:0]          word_reg;
    logic [WW-1:0]          word_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          removed_reg;
    logic [CW-1:0]          removed_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [31:0]            read_word_reg;
    logic [31:0]            read_word_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [4:0]             entry_count_reg;
    logic [4:0]             entry_count_next;
    logic [4:0]             removed_count_reg;
    logic [4:0]             removed_count_next;

    ilsd_pkg::cell_ctrl_t   ctrl;
    ilsd_pkg::cell_stat_t   cell_stat [CAP];
    logic [WW-1:0]          cell_word [CAP];
    logic [CAP-1:0]         stacked;
    logic                   any_hole;
    logic                   last_hole;
    logic                   shift_en;
    logic                   out_free;
    logic                   pos_ok;
    logic [IW+3:0]          pos_ext;
    logic [IW-1:0]          pos_idx;
    logic [CW-1:0]          count_dec;
    logic [IW-1:0]          rd_idx;
    logic [WW-1:0]          rd_word;

    // Cell row: each cell hears the broadcast command and both of its neighbors.
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [WW-1:0] up_word;
        logic          up_drop;
        logic          hole_in;

        if (i == CAP - 1)
        begin : g_top
            assign up_word = '0;
            assign up_drop = 1'b0;
        end
        else
        begin : g_mid
            assign up_word = cell_word[i+1];
            assign up_drop = cell_stat[i+1].drop;
        end

        if (i == 0)
        begin : g_bottom
            assign hole_in    = 1'b0;
            assign stacked[i] = 1'b0;
        end
        else
        begin : g_upper
            assign hole_in    = cell_stat[i-1].hole;
            assign stacked[i] = cell_stat[i].drop & cell_stat[i-1].hole;
        end

        ilsd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IW'(i)),
            .ctrl     (ctrl),
            .up_word  (up_word),
            .up_drop  (up_drop),
            .hole_in  (hole_in),
            .word     (cell_word[i]),
            .stat     (cell_stat[i])
        );
    end

    // Gap tracking: any mark at all, and whether only one mark is left.
    assign any_hole  = cell_stat[CAP-1].hole;
    assign last_hole = any_hole && !(|stacked);

    // Index checks and the single read port over the cell row.
    assign pos_ok    = ({{CW{1'b0}}, pos_reg} < {4'b0, count_reg});
    assign pos_ext   = {{IW{1'b0}}, pos_reg};
    assign pos_idx   = pos_ext[IW-1:0];
    assign count_dec = count_reg - CW'(1);
    assign rd_idx    = (op_reg == ilsd_pkg::OP_POP) ? count_dec[IW-1:0] : pos_idx;
    assign rd_word   = cell_word[rd_idx];
    assign out_free  = !out_valid_reg || out_ready;

    // Controller next-state logic.
    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        pos_next           = pos_reg;
        word_next          = word_reg;
        count_next         = count_reg;
        removed_next       = removed_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        read_word_next     = read_word_reg;
        status_next        = status_reg;
        entry_count_next   = entry_count_reg;
        removed_count_next = removed_count_reg;
        ctrl.cmd           = ilsd_pkg::CMD_HOLD;
        ctrl.sel           = pos_idx;
        ctrl.count         = count_reg;
        ctrl.word          = word_reg;
        shift_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    pos_next   = position;
                    word_next  = ilsd_pkg::to_entry(operand_word);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (op_reg == ilsd_pkg::OP_REMOVE_EQ)
                begin
                    // Mark every live match, then compact.
                    ctrl.cmd     = ilsd_pkg::CMD_MARK_EQ;
                    removed_next = '0;
                    state_next   = S_COMPACT;
                end
                else if (op_reg == ilsd_pkg::OP_REMOVE_AT && pos_ok)
                begin
                    ctrl.cmd     = ilsd_pkg::CMD_MARK_AT;
                    removed_next = '0;
                    state_next   = S_COMPACT;
                end
                else if (out_free)
                begin
                    // Single-step operations finish here.
                    read_word_next     = 32'd0;
                    status_next        = ilsd_pkg::ST_OK;
                    removed_count_next = 5'd0;
                    case (op_reg)
                        ilsd_pkg::OP_GET:
                        begin
                            if (pos_ok)
                            begin
                                read_word_next = ilsd_pkg::to_out_word(rd_word);
                            end
                            else
                            begin
                                status_next = ilsd_pkg::ST_RANGE;
                            end
                        end
                        ilsd_pkg::OP_SET:
                        begin
                            if (pos_ok)
                            begin
                                ctrl.cmd = ilsd_pkg::CMD_LOAD;
                            end
                            else
                            begin
                                status_next = ilsd_pkg::ST_RANGE;
                            end
                        end
                        ilsd_pkg::OP_PUSH:
                        begin
                            if (count_reg >= CW'(CAP))
                            begin
                                status_next = ilsd_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd   = ilsd_pkg::CMD_LOAD;
                                ctrl.sel   = count_reg[IW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ilsd_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ilsd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                read_word_next     = ilsd_pkg::to_out_word(rd_word);
                                count_next         = count_dec;
                                removed_count_next = 5'd1;
                            end
                        end
                        ilsd_pkg::OP_REMOVE_AT:
                        begin
                            status_next = ilsd_pkg::ST_RANGE;
                        end
                        default:
                        begin
                            status_next = ilsd_pkg::ST_OK;
                        end
                    endcase
                    entry_count_next = ilsd_pkg::to_out_count(count_next);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_COMPACT:
            begin
                // Close the lowest gap each cycle; the last one ends the request.
                if (any_hole && !last_hole)
                begin
                    shift_en = 1'b1;
                end
                else if (out_free)
                begin
                    shift_en           = any_hole;
                    read_word_next     = 32'd0;
                    status_next        = ilsd_pkg::ST_OK;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
                if (shift_en)
                begin
                    ctrl.cmd     = ilsd_pkg::CMD_SHIFT;
                    count_next   = count_dec;
                    removed_next = removed_reg + CW'(1);
                end
                if (state_next == S_IDLE)
                begin
                    entry_count_next   = ilsd_pkg::to_out_count(count_next);
                    removed_count_next = ilsd_pkg::to_out_count(removed_next);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        pos_reg           <= pos_next;
        word_reg          <= word_next;
        read_word_reg     <= read_word_next;
        status_reg        <= status_next;
        entry_count_reg   <= entry_count_next;
        removed_count_reg <= removed_count_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign read_word     = read_word_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;
    assign removed_count = removed_count_reg;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("entry count exceeds capacity");

    // Every shift closes exactly one gap.
    a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |=> count_reg == $past(count_reg) - CW'(1))
        else $error("shift did not decrement the count");

    // No drop mark survives once a request is finished.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !any_hole)
        else $error("drop mark left in an idle list");

    // A result appears only at the end of a request's work.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) != S_IDLE)
        else $error("result raised without a request in progress");

endmodule
